FILE: rtl/core/blos_pkg.sv
package blos_pkg;

  // default store depth
  localparam int CAPACITY_DEF = 16;

  // field widths
  localparam int KIND_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 4;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_FRONT   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_APPEND  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ORDERED = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ    = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  // write command broadcast to every cell of the chain
  typedef struct packed {
    logic                      front;
    logic                      append;
    logic                      ordered;
    logic signed [VALUE_W-1:0] value;
  } cell_ctrl_t;

endpackage

FILE: rtl/core/blos_cell.sv
module blos_cell #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic                               clk,
  input  blos_pkg::cell_ctrl_t               ctrl,
  input  logic [CW-1:0]                      count,
  input  logic signed [blos_pkg::VALUE_W-1:0] left_entry,
  input  logic                               found_in,
  output logic                               found_out,
  output logic signed [blos_pkg::VALUE_W-1:0] entry
);

  logic signed [blos_pkg::VALUE_W-1:0] entry_r;
  logic signed [blos_pkg::VALUE_W-1:0] entry_nxt;
  logic                                occupied;
  logic                                stop;
  logic                                at_end;

  // this cell holds a live entry
  assign occupied = CW'(IDX) < count;
  assign at_end   = CW'(IDX) == count;

  // ordered insert stops at the first entry not less than the value
  assign stop      = !(occupied && (entry_r < ctrl.value));
  assign found_out = found_in | stop;

  // shift from the left neighbor, take the new value, or hold
  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.front) begin
      entry_nxt = left_entry;
    end else if (ctrl.append && at_end) begin
      entry_nxt = ctrl.value;
    end else if (ctrl.ordered) begin
      if (found_in) begin
        entry_nxt = left_entry;
      end else if (stop) begin
        entry_nxt = ctrl.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

FILE: rtl/core/bounded_ordered_list_store.sv
// Bounded ordered list store.
// Input channel (in_valid/in_ready) carries one request: in_kind selects
// insert at front, append, ordered insert, clear or read of in_position;
// in_value is the signed value to insert.
// Result channel (out_valid/out_ready) returns one result per request:
// out_status, out_count (count after the request, low 5 bits) and
// out_read_value (entry read, zero otherwise).
// Entries live in a row of cells; every insert shifts or loads the affected
// cells in the same cycle, and each result is registered on acceptance and
// appears in the cycle after. Throughput is one request per cycle while the receiver keeps up.
// The output register holds a result while the receiver stalls; in_ready
// stays high as long as that register is empty or being drained, so a
// stalled receiver holds off new requests after one result is waiting.
// Reset empties the store (count zero) and drops any pending result.
// Cell contents are not cleared; positions at or beyond the count are
// never returned.
module bounded_ordered_list_store #(
  parameter int CAPACITY = blos_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [blos_pkg::KIND_W-1:0]         in_kind,
  input  logic signed [blos_pkg::VALUE_W-1:0] in_value,
  input  logic [blos_pkg::POS_W-1:0]          in_position,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [blos_pkg::STATUS_W-1:0]       out_status,
  output logic [blos_pkg::COUNT_W-1:0]        out_count,
  output logic signed [blos_pkg::VALUE_W-1:0] out_read_value
);

  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int OCW    = blos_pkg::COUNT_W;
  localparam int NRD    = (CAPACITY < (1 << blos_pkg::POS_W)) ?
                          CAPACITY : (1 << blos_pkg::POS_W);

  logic [CW-1:0]                       count_r;
  logic [CW-1:0]                       count_nxt;
  logic                                out_valid_r;
  logic [blos_pkg::STATUS_W-1:0]       status_r;
  logic [blos_pkg::STATUS_W-1:0]       status_nxt;
  logic [OCW-1:0]                      ocount_r;
  logic signed [blos_pkg::VALUE_W-1:0] rdata_r;
  logic signed [blos_pkg::VALUE_W-1:0] rdata_nxt;

  logic                                accept;
  logic                                full;
  blos_pkg::cell_ctrl_t                ctrl;
  logic signed [blos_pkg::VALUE_W-1:0] ent  [CAPACITY];
  logic signed [blos_pkg::VALUE_W-1:0] left [CAPACITY];
  logic [CAPACITY:0]                   found;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = count_r == CW'(CAPACITY);

  // decode the request into next count, status, read data and cell command
  always_comb begin
    count_nxt    = count_r;
    status_nxt   = blos_pkg::ST_DONE;
    rdata_nxt    = '0;
    ctrl.front   = 1'b0;
    ctrl.append  = 1'b0;
    ctrl.ordered = 1'b0;
    ctrl.value   = in_value;
    case (in_kind)
      blos_pkg::KIND_FRONT, blos_pkg::KIND_APPEND, blos_pkg::KIND_ORDERED: begin
        if (full) begin
          status_nxt = blos_pkg::ST_FULL;
        end else begin
          count_nxt    = count_r + CW'(1);
          ctrl.front   = accept && (in_kind == blos_pkg::KIND_FRONT);
          ctrl.append  = accept && (in_kind == blos_pkg::KIND_APPEND);
          ctrl.ordered = accept && (in_kind == blos_pkg::KIND_ORDERED);
        end
      end
      blos_pkg::KIND_CLEAR: begin
        count_nxt = '0;
      end
      blos_pkg::KIND_READ: begin
        if ((32'(in_position) < 32'(count_r)) && (32'(in_position) < 32'(CAPACITY))) begin
          for (int i = 0; i < NRD; i++) begin
            if (in_position == blos_pkg::POS_W'(i)) begin
              rdata_nxt = ent[i];
            end
          end
        end else begin
          status_nxt = blos_pkg::ST_RANGE;
        end
      end
      default: begin
      end
    endcase
  end

  // row of entry cells, each fed by its left neighbor (the first by in_value)
  assign found[0] = 1'b0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign left[g] = in_value;
    end else begin : g_body
      assign left[g] = ent[g-1];
    end

    blos_cell #(
      .IDX (g),
      .CW  (CW)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .count      (count_r),
      .left_entry (left[g]),
      .found_in   (found[g]),
      .found_out  (found[g+1]),
      .entry      (ent[g])
    );
  end

  // count and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      ocount_r <= OCW'(count_nxt);
      rdata_r  <= rdata_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_count      = ocount_r;
  assign out_read_value = rdata_r;

endmodule
